/* src/uvcfs_pkg.sv */
`default_nettype none

package uvcfs_pkg;

    localparam int unsigned HDR_LEN     = 12;
    localparam int unsigned MIN_CHUNK   = 13;
    localparam logic [11:0] CHUNK_RESET = 12'd2040;

    localparam int unsigned FLAG_FID_BIT = 0;
    localparam int unsigned FLAG_EOF_BIT = 1;
    localparam int unsigned FLAG_PTS_BIT = 2;
    localparam int unsigned FLAG_ERR_BIT = 6;

    localparam int unsigned Q_DEPTH = 4;

    typedef enum logic [1:0] {
        CK_FIRST   = 2'd0,
        CK_INTER   = 2'd1,
        CK_LAST    = 2'd2,
        CK_DISCARD = 2'd3
    } t_ckind;

    typedef enum logic [1:0] {
        RK_CLOSE   = 2'd0,
        RK_BEGIN   = 2'd1,
        RK_PAYLOAD = 2'd2
    } t_rkind;

    typedef struct packed {
        t_rkind     rkind;
        t_ckind     ckind;
        logic [7:0] data;
        logic       chunk_last;
        logic       run_last;
    } t_res;

endpackage

`default_nettype wire

/* src/uvc_payload_frame_splitter.sv */
// Payload header deframer for a byte stream of transfers.
// Slave channel: one transfer byte per word, tlast on the final byte of a
// transfer. Each transfer is cut into chunks of at most chunk_size bytes
// (13 if smaller), each led by a 12-byte header that is checked and classified.
// Master channel: per word a result kind and chunk kind in tuser, the payload
// byte and an end-of-chunk flag in tdata, tlast on the final result of the
// input byte. Header byte 11 of an accepted chunk yields a chunk-begins word,
// preceded by a data-less close word when a frame boundary follows an inter
// chunk; each later byte yields one payload word.
// chunk_size is written through i_cfg_we/i_cfg_wdata; the user must do so only
// while idle, which the block does not enforce. Results are registered in the
// output queue. Throughput: one byte per cycle while s_tready is high; a
// four-word result queue absorbs the extra close word, and s_tready drops
// only when it holds three or more words. When the receiver stalls, results
// collect in the queue; input is held off once it cannot take two more words.
// Reset clears the chunk state, stored PTS/FID and queue; chunk_size returns
// to 2040.
`default_nettype none

module uvc_payload_frame_splitter
    import uvcfs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tlast,   // end_of_transfer
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [8] last_of_chunk, rest zero
    output logic [3:0]  m_tuser,   // [1:0] result_kind, [3:2] chunk_kind
    output logic        m_tlast,   // run_last
    input  wire         i_cfg_we,
    input  wire  [11:0] i_cfg_wdata
);

    logic [11:0] r_chunk_size;
    logic        accept;
    logic        room;
    t_res [1:0]  res;
    logic [1:0]  res_cnt;
    logic [1:0]  push_cnt;
    t_res        head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size <= CHUNK_RESET;
        end else if (i_cfg_we) begin
            r_chunk_size <= i_cfg_wdata;
        end
    end

    assign s_tready = room;
    assign accept   = s_tvalid && room;
    assign push_cnt = accept ? res_cnt : 2'd0;

    uvcfs_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (s_tdata),
        .i_eot        (s_tlast),
        .i_chunk_size (r_chunk_size),
        .o_res        (res),
        .o_res_cnt    (res_cnt)
    );

    uvcfs_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .i_push_cnt (push_cnt),
        .i_pop      (m_tready),
        .o_room     (room),
        .o_valid    (m_tvalid),
        .o_head     (head)
    );

    assign m_tdata = {7'd0, head.chunk_last, head.data};
    assign m_tuser = {head.ckind, head.rkind};
    assign m_tlast = head.run_last;

endmodule

`default_nettype wire

/* src/uvcfs_parse.sv */
`default_nettype none

module uvcfs_parse
    import uvcfs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_accept,
    input  wire  [7:0]  i_byte,
    input  wire         i_eot,
    input  wire  [11:0] i_chunk_size,
    output t_res [1:0]  o_res,
    output logic [1:0]  o_res_cnt
);

    logic [11:0] r_pos,   n_pos;
    logic [7:0]  r_flags, n_flags;
    logic [31:0] r_pts,   n_pts;
    logic [31:0] r_spts,  n_spts;
    logic        r_sfid,  n_sfid;
    t_ckind      r_prev,  n_prev;
    t_ckind      r_cur,   n_cur;
    logic        r_drop,  n_drop;

    logic [11:0] eff_m1;
    logic        ends;
    logic        fid;
    logic        emit_hdr;
    t_ckind      kind;
    logic        close;
    t_res        res_close;
    t_res        res_main;

    always_comb begin
        eff_m1 = (i_chunk_size < 12'(MIN_CHUNK)) ? 12'(MIN_CHUNK - 1) : (i_chunk_size - 12'd1);
        ends   = i_eot || (r_pos >= eff_m1);

        n_flags = r_flags;
        n_pts   = r_pts;
        n_drop  = r_drop;
        n_spts  = r_spts;
        n_sfid  = r_sfid;
        n_prev  = r_prev;
        n_cur   = r_cur;

        if (r_pos == 12'd0) begin
            n_drop  = (i_byte != 8'(HDR_LEN));
            n_flags = 8'd0;
            n_pts   = 32'd0;
        end else if (!r_drop) begin
            case (r_pos)
                12'd1: begin
                    n_flags = i_byte;
                    n_drop  = i_byte[FLAG_ERR_BIT] || !i_byte[FLAG_PTS_BIT];
                end
                12'd2: n_pts[7:0]   = i_byte;
                12'd3: n_pts[15:8]  = i_byte;
                12'd4: n_pts[23:16] = i_byte;
                12'd5: n_pts[31:24] = i_byte;
                default: ;
            endcase
        end
        if (n_drop) begin
            n_prev = CK_DISCARD;
        end

        fid      = n_flags[FLAG_FID_BIT];
        emit_hdr = !n_drop && (r_pos == 12'(HDR_LEN - 1));
        close    = 1'b0;
        kind     = CK_INTER;
        if ((n_pts != r_spts) || (fid != r_sfid)) begin
            kind  = CK_FIRST;
            close = (r_prev == CK_INTER);
        end else if (n_flags[FLAG_EOF_BIT]) begin
            kind = CK_LAST;
        end

        res_close = '{rkind: RK_CLOSE, ckind: CK_LAST, data: 8'd0,
                      chunk_last: 1'b0, run_last: 1'b0};
        res_main  = '{rkind: RK_PAYLOAD, ckind: r_cur, data: i_byte,
                      chunk_last: ends, run_last: 1'b1};
        o_res_cnt = 2'd0;

        if (emit_hdr) begin
            res_main = '{rkind: RK_BEGIN, ckind: kind, data: 8'd0,
                         chunk_last: ends, run_last: 1'b1};
            n_cur  = kind;
            n_prev = kind;
            if (kind == CK_FIRST) begin
                n_spts = n_pts;
                n_sfid = fid;
            end else if (kind == CK_LAST) begin
                n_spts = 32'd0;
            end
            o_res_cnt = close ? 2'd2 : 2'd1;
        end else if (!n_drop && (r_pos >= 12'(HDR_LEN))) begin
            o_res_cnt = 2'd1;
        end

        if (close && emit_hdr) begin
            o_res[0] = res_close;
            o_res[1] = res_main;
        end else begin
            o_res[0] = res_main;
            o_res[1] = res_main;
        end

        if (ends && (r_pos < 12'(HDR_LEN - 1))) begin
            n_drop = 1'b1;
            n_prev = CK_DISCARD;
        end

        n_pos = ends ? 12'd0 : (r_pos + 12'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 12'd0;
            r_flags <= 8'd0;
            r_pts   <= 32'd0;
            r_spts  <= 32'd0;
            r_sfid  <= 1'b0;
            r_prev  <= CK_DISCARD;
            r_cur   <= CK_FIRST;
            r_drop  <= 1'b0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_flags <= n_flags;
            r_pts   <= n_pts;
            r_spts  <= n_spts;
            r_sfid  <= n_sfid;
            r_prev  <= n_prev;
            r_cur   <= n_cur;
            r_drop  <= n_drop;
        end
    end

endmodule

`default_nettype wire

/* src/uvcfs_outq.sv */
`default_nettype none

module uvcfs_outq
    import uvcfs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_res [1:0] i_res,
    input  wire  [1:0]  i_push_cnt,
    input  wire         i_pop,
    output logic        o_room,
    output logic        o_valid,
    output t_res        o_head
);

    localparam int unsigned CW = $clog2(Q_DEPTH + 1);
    localparam int unsigned IW = $clog2(Q_DEPTH);

    t_res [Q_DEPTH-1:0] r_q, n_q;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      base;

    always_comb begin
        n_q  = r_q;
        base = r_cnt;
        if (i_pop && (r_cnt != '0)) begin
            for (int i = 0; i < Q_DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
            base = r_cnt - CW'(1);
        end
        for (int i = 0; i < Q_DEPTH; i++) begin
            if ((i_push_cnt != 2'd0) && (IW'(i) == base[IW-1:0])) begin
                n_q[i] = i_res[0];
            end
            if ((i_push_cnt == 2'd2) && (IW'(i) == IW'(base + CW'(1)))) begin
                n_q[i] = i_res[1];
            end
        end
        n_cnt = base + CW'(i_push_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_room  = (r_cnt <= CW'(Q_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[0];

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import uvcfs_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned TAIL_CYCLES    = 10;
    localparam int unsigned PHASE_BYTES    = 270;
    localparam int unsigned BLOCK_BYTES    = 70;

    localparam logic [7:0] F_FID = 8'(1) << FLAG_FID_BIT;
    localparam logic [7:0] F_EOF = 8'(1) << FLAG_EOF_BIT;
    localparam logic [7:0] F_PTS = 8'(1) << FLAG_PTS_BIT;
    localparam logic [7:0] F_ERR = 8'(1) << FLAG_ERR_BIT;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        i_cfg_we    = 1'b0;
    logic [11:0] i_cfg_wdata = 12'd0;

    uvc_payload_frame_splitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // deframer state mirror
    logic [11:0] cfg_chunk   = CHUNK_RESET;
    logic [11:0] chunk_pos   = 12'd0;
    logic [7:0]  hdr_flags   = 8'h00;
    logic [31:0] pts_acc     = 32'd0;
    logic [31:0] frame_pts   = 32'd0;
    logic        frame_fid   = 1'b0;
    t_ckind      prev_kind   = CK_DISCARD;
    t_ckind      cur_kind    = CK_FIRST;
    bit          dropping    = 1'b0;

    t_res        pending_words[$];
    int          error_count = 0;
    int unsigned bytes_sent  = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;

    // stimulus-side guess of the running frame, to bias toward matching headers
    logic [31:0] gen_pts = 32'd0;
    logic        gen_fid = 1'b0;

    function automatic t_res make_word(t_rkind rk, t_ckind ck, logic [7:0] data,
                                       logic chunk_last);
        t_res w;
        w.rkind      = rk;
        w.ckind      = ck;
        w.data       = data;
        w.chunk_last = chunk_last;
        w.run_last   = 1'b0;
        return w;
    endfunction

    function automatic logic [11:0] eff_chunk();
        return (cfg_chunk < MIN_CHUNK) ? 12'(MIN_CHUNK) : cfg_chunk;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic eot);
        logic [11:0] p;
        logic [11:0] eff;
        bit          ends;
        t_ckind      kind;
        logic        fid;
        t_res        words[$];
        p    = chunk_pos;
        eff  = eff_chunk();
        ends = eot || (p >= eff - 12'd1);
        if (p == 0) begin
            dropping  = (b != HDR_LEN);
            hdr_flags = 8'h00;
            pts_acc   = 32'd0;
        end else if (!dropping) begin
            if (p == 1) begin
                hdr_flags = b;
                if (b[FLAG_ERR_BIT] || !b[FLAG_PTS_BIT])
                    dropping = 1'b1;
            end else if (p >= 2 && p <= 5) begin
                pts_acc |= 32'(b) << (8 * (p - 2));
            end
        end
        if (dropping)
            prev_kind = CK_DISCARD;

        if (!dropping && p == HDR_LEN - 1) begin
            fid = hdr_flags[FLAG_FID_BIT];
            if (pts_acc != frame_pts || fid != frame_fid) begin
                if (prev_kind == CK_INTER)
                    words.push_back(make_word(RK_CLOSE, CK_LAST, 8'h00, 1'b0));
                frame_pts = pts_acc;
                frame_fid = fid;
                kind = CK_FIRST;
            end else if (hdr_flags[FLAG_EOF_BIT]) begin
                frame_pts = 32'd0;
                kind = CK_LAST;
            end else begin
                kind = CK_INTER;
            end
            cur_kind  = kind;
            prev_kind = kind;
            words.push_back(make_word(RK_BEGIN, kind, 8'h00, ends));
        end else if (!dropping && p >= HDR_LEN) begin
            words.push_back(make_word(RK_PAYLOAD, cur_kind, b, ends));
        end

        if (ends && p < HDR_LEN - 1) begin
            dropping  = 1'b1;
            prev_kind = CK_DISCARD;
        end
        chunk_pos = ends ? 12'd0 : p + 12'd1;

        if (words.size() > 0)
            words[words.size() - 1].run_last = 1'b1;
        foreach (words[i])
            pending_words.push_back(words[i]);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_res e;
        if (i_rst_n && s_tvalid && s_tready)
            deframe_byte(s_tdata, s_tlast);
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: tuser %h tdata %h tlast %b",
                       m_tuser, m_tdata, m_tlast);
                error_count++;
            end else begin
                e = pending_words.pop_front();
                check_field("result_kind", e.rkind, m_tuser[1:0]);
                check_field("chunk_kind", e.ckind, m_tuser[3:2]);
                check_field("payload_byte", e.data, m_tdata[7:0]);
                check_field("last_of_chunk", e.chunk_last, m_tdata[8]);
                check_field("run_last", e.run_last, m_tlast);
            end
        end
    end

    always @(posedge i_clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge i_clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        // let the scoreboard record the last accepted byte first
        @(posedge i_clk);
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_chunk_size(input logic [11:0] v);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_chunk = v;
    endtask

    task automatic send_chunk_bytes(input logic [7:0] len_byte, input logic [7:0] flags,
                                    input logic [31:0] pts, input int unsigned n_bytes,
                                    input bit ends_xfer);
        logic [7:0] b;
        for (int unsigned i = 0; i < n_bytes; i++) begin
            if (i == 0)
                b = len_byte;
            else if (i == 1)
                b = flags;
            else if (i <= 5)
                b = pts[8 * (i - 2) +: 8];
            else
                b = 8'($urandom_range(255));
            send_byte(b, ends_xfer && (i == n_bytes - 1));
        end
    endtask

    task automatic send_random_chunk(input int unsigned n_bytes, input bit ends_xfer);
        logic [7:0]  len_byte;
        logic [7:0]  flags;
        logic [31:0] pts;
        int unsigned r;
        len_byte = 8'(HDR_LEN);
        if ($urandom_range(99) < 5)
            do len_byte = 8'($urandom_range(255)); while (len_byte == HDR_LEN);
        flags = 8'($urandom_range(255));
        flags[FLAG_ERR_BIT] = ($urandom_range(99) < 5);
        flags[FLAG_PTS_BIT] = ($urandom_range(99) >= 5);
        flags[FLAG_EOF_BIT] = ($urandom_range(99) < 30);
        flags[FLAG_FID_BIT] = ($urandom_range(99) < 80) ? gen_fid : ~gen_fid;
        r = $urandom_range(99);
        if (r < 55)
            pts = gen_pts;
        else if (r < 70)
            pts = 32'd0;
        else if (r < 80)
            pts = 32'hFFFF_FFFF;
        else
            pts = $urandom;
        gen_pts = pts;
        gen_fid = flags[FLAG_FID_BIT];
        send_chunk_bytes(len_byte, flags, pts, n_bytes, ends_xfer);
    endtask

    task automatic send_random_transfer();
        int unsigned eff;
        int unsigned n_full;
        int unsigned tail_len;
        int unsigned r;
        eff    = eff_chunk();
        n_full = (eff <= 40) ? $urandom_range(0, 2) : 0;
        repeat (n_full) send_random_chunk(eff, 1'b0);
        r = $urandom_range(99);
        if (r < 8)
            tail_len = $urandom_range(1, HDR_LEN - 1);
        else if (r < 18)
            tail_len = HDR_LEN;
        else
            tail_len = $urandom_range(MIN_CHUNK, (eff < 40) ? eff : 40);
        send_random_chunk(tail_len, 1'b1);
    endtask

    function automatic logic [11:0] pick_chunk_size();
        case ($urandom_range(9))
            0:       return 12'(MIN_CHUNK);
            1:       return 12'd4095;
            2:       return CHUNK_RESET;
            3:       return 12'($urandom_range(0, MIN_CHUNK - 1));
            default: return 12'($urandom_range(MIN_CHUNK, 40));
        endcase
    endfunction

    // first, inter, then a new PTS that closes the open frame
    task automatic test_frame_kinds();
        send_chunk_bytes(HDR_LEN, F_PTS | F_FID | F_EOF, 32'hFFFF_FFFF, HDR_LEN, 1'b1);
        send_chunk_bytes(HDR_LEN, F_PTS | F_FID, 32'hFFFF_FFFF, HDR_LEN + 1, 1'b1);
        send_chunk_bytes(HDR_LEN, F_PTS, 32'h1234_5678, HDR_LEN, 1'b1);
    endtask

    task automatic test_dropped_headers();
        send_chunk_bytes(8'(HDR_LEN - 1), F_PTS, 32'd0, 1, 1'b1);
        send_chunk_bytes(HDR_LEN, F_PTS | F_ERR, 32'd0, 2, 1'b1);
        send_chunk_bytes(HDR_LEN, F_FID, 32'd0, 2, 1'b1);
    endtask

    // size below the floor: chunk cut at 13 bytes, then a short leftover
    task automatic test_min_chunk_size();
        set_chunk_size(12'd0);
        send_chunk_bytes(HDR_LEN, F_PTS | F_EOF, 32'h1234_5678, MIN_CHUNK, 1'b0);
        send_chunk_bytes(HDR_LEN, F_PTS, 32'd0, 1, 1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct);
        int unsigned phase_end;
        int unsigned block_end;
        wait_results_drained();
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        phase_end = bytes_sent + PHASE_BYTES;
        while (bytes_sent < phase_end) begin
            set_chunk_size(pick_chunk_size());
            block_end = bytes_sent + BLOCK_BYTES;
            while (bytes_sent < block_end)
                send_random_transfer();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frame_kinds();
        test_dropped_headers();
        test_min_chunk_size();
        set_chunk_size(12'd4095);
        test_random_traffic(30, 49);
        test_random_traffic(49, 30);
        test_random_traffic(0, 0);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_words.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
